>>> rtl/dds_pkg.sv
// ---------------------------------------------------------------------------
// dds_pkg
// Shared types and constants of the differential-drive duty mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned MID_W   = 7;
  localparam int unsigned MCAND_W = 9;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned DEN_W   = 14;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned BASE_W  = 21;
  localparam int unsigned RAW_W   = 22;
  localparam int unsigned WIDE_W  = 23;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // serial step counts
  localparam int unsigned MUL_STEPS = MID_W;
  localparam int unsigned DIV_STEPS = QUOT_W;

  // duty constants
  localparam logic [DUTY_W-1:0] DUTY_NEUTRAL = 7'd75;
  localparam logic [DUTY_W-1:0] DUTY_MIN     = 7'd50;
  localparam logic [DUTY_W-1:0] DUTY_MAX     = 7'd99;
  localparam logic [BASE_W-1:0] NEUTRAL_MULT = 21'd75;
  localparam logic signed [WIDE_W-1:0] RANGE_MULT = 23'sd25;

  // register reset values
  localparam logic [BYTE_W-1:0] TFS_RESET  = 8'd255;
  localparam logic [BYTE_W-1:0] DFS_RESET  = 8'd255;
  localparam logic [STEP_W-1:0] STEP_RESET = 6'd20;

  // register indexes (word address)
  localparam logic [1:0] REG_TFS  = 2'd0;
  localparam logic [1:0] REG_DFS  = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RAW,
    ST_DIV,
    ST_FIN
  } state_t;

  // control of a serial lane
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/dds_mul.sv
// ---------------------------------------------------------------------------
// dds_mul
// Shift-add multiplier lane: one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dds_mul
  import dds_pkg::*;
(
  input  wire logic                     clk,
  input  wire lane_ctl_t                ctl,
  input  wire logic signed [MCAND_W-1:0] mcand,
  input  wire logic [MID_W-1:0]         mplier,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] mcand_r;
  logic [MID_W-1:0]         mplier_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r    <= '0;
      mcand_r  <= PROD_W'(mcand);
      mplier_r <= mplier;
    end else if (ctl.step) begin
      // add the shifted multiplicand where the multiplier bit is set
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign prod = acc_r;

endmodule

`default_nettype wire

>>> rtl/dds_div.sv
// ---------------------------------------------------------------------------
// dds_div
// Restoring divider lane: one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dds_div
  import dds_pkg::*;
(
  input  wire logic              clk,
  input  wire lane_ctl_t         ctl,
  input  wire logic [RAW_W-1:0]  dividend,
  input  wire logic [DEN_W-1:0]  divisor,
  output logic [QUOT_W-1:0]      quot
);

  logic [DEN_W:0]    rem_r;
  logic [QUOT_W-1:0] low_r;
  logic [DEN_W-1:0]  dvs_r;
  logic [DEN_W:0]    trial;
  logic              fits;

  // the remainder stays below the divisor, so its top bit is always clear
  assign trial = {rem_r[DEN_W-1:0], low_r[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // quotient is below 2^QUOT_W, so the high part is already below the divisor
      rem_r <= (DEN_W+1)'(dividend[RAW_W-1:QUOT_W]);
      low_r <= dividend[QUOT_W-1:0];
      dvs_r <= divisor;
    end else if (ctl.step) begin
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
      low_r <= {low_r[QUOT_W-2:0], fits};
    end
  end

  assign quot = low_r;

endmodule

`default_nettype wire

>>> rtl/differential_drive_mixer_slew.sv
// ---------------------------------------------------------------------------
// differential_drive_mixer_slew
// Mixes throttle and direction into two motor duties, clamps them to 50..99
// and limits the change of each duty per command.
// ---------------------------------------------------------------------------
//   channel | ports                                   | transfer
//   in      | in_kind, in_throttle, in_direction      | in_valid & in_ready
//   out     | out_duty_left, out_duty_right           | out_valid & out_ready
//   cfg     | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite
//
// A command runs, after its transfer, through the shift-add multiplier lanes
// (ST_MUL), the numerator and divider-load steps (ST_SUM, ST_RAW), the
// restoring divider lanes (ST_DIV, one bit per cycle each) and the result
// write (ST_FIN), then returns to idle; out_valid is registered from that write.
// The result register is held until taken; a finished command waits in the
// last step while the previous result is untaken, and in_ready stays low meanwhile.
// Synchronous reset sets both duties to 75 and the registers to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module differential_drive_mixer_slew
  import dds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [BYTE_W-1:0] in_throttle,
  input  wire logic [BYTE_W-1:0] in_direction,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DUTY_W-1:0]      out_duty_left,
  output logic [DUTY_W-1:0]      out_duty_right,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  function automatic logic [DUTY_W-1:0] ramp_duty(input logic [QUOT_W-1:0] q,
                                                   input logic [DUTY_W-1:0] cur,
                                                   input logic [STEP_W-1:0] step);
    logic [DUTY_W-1:0]      qc;
    logic signed [DUTY_W+1:0] lo;
    logic signed [DUTY_W+1:0] hi;
    logic signed [DUTY_W+1:0] qs;
    logic [DUTY_W-1:0]      res;
    if (q < {1'b0, DUTY_MIN}) begin
      qc = DUTY_MIN;
    end else if (q > {1'b0, DUTY_MAX}) begin
      qc = DUTY_MAX;
    end else begin
      qc = q[DUTY_W-1:0];
    end
    lo = $signed({2'b0, cur}) - $signed({3'b0, step});
    hi = $signed({2'b0, cur}) + $signed({3'b0, step});
    qs = $signed({2'b0, qc});
    if (qs < lo) begin
      res = lo[DUTY_W-1:0];
    end else if (qs > hi) begin
      res = hi[DUTY_W-1:0];
    end else begin
      res = qc;
    end
    return res;
  endfunction

  // configuration registers
  logic [BYTE_W-1:0] tfs_r;
  logic [BYTE_W-1:0] dfs_r;
  logic [STEP_W-1:0] step_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tfs_r  <= TFS_RESET;
      dfs_r  <= DFS_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TFS:  tfs_r  <= pwdata[BYTE_W-1:0];
        REG_DFS:  dfs_r  <= pwdata[BYTE_W-1:0];
        REG_STEP: step_r <= pwdata[STEP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TFS:  prdata = DATA_W'(tfs_r);
      REG_DFS:  prdata = DATA_W'(dfs_r);
      REG_STEP: prdata = DATA_W'(step_r);
      default:  prdata = '0;
    endcase
  end

  // midpoints and capped inputs
  logic [MID_W-1:0]          mt;
  logic [MID_W-1:0]          md;
  logic [BYTE_W-1:0]         t_eff;
  logic [BYTE_W-1:0]         d_eff;
  logic signed [MCAND_W-1:0] t_off;
  logic signed [MCAND_W-1:0] d_off;

  always_comb begin
    mt = (tfs_r[BYTE_W-1:1] == '0) ? MID_W'(1) : tfs_r[BYTE_W-1:1];
    md = (dfs_r[BYTE_W-1:1] == '0) ? MID_W'(1) : dfs_r[BYTE_W-1:1];
    if (in_kind) begin
      t_eff = {1'b0, mt};
      d_eff = {1'b0, md};
    end else begin
      t_eff = (in_throttle > tfs_r) ? tfs_r : in_throttle;
      d_eff = (in_direction > dfs_r) ? dfs_r : in_direction;
    end
    t_off = $signed({1'b0, t_eff}) - $signed({2'b0, mt});
    d_off = $signed({1'b0, d_eff}) - $signed({2'b0, md});
  end

  // sequencer
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  lane_ctl_t         mul_ctl;
  lane_ctl_t         div_ctl;
  logic              fin_load;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mul_ctl      = '0;
    div_ctl      = '0;
    fin_load     = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mul_ctl.load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        div_ctl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          fin_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r & ~out_ready) | fin_load;
  end

  // multiplier lanes: den = mt*md, p1 = (t-mt)*md, p2 = (d-md)*mt
  logic signed [PROD_W-1:0] den_p;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  dds_mul u_mul_den (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  ($signed({2'b0, mt})),
    .mplier (md),
    .prod   (den_p)
  );

  dds_mul u_mul_thr (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (t_off),
    .mplier (md),
    .prod   (p1)
  );

  dds_mul u_mul_dir (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (d_off),
    .mplier (mt),
    .prod   (p2)
  );

  // numerators over the common denominator
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  dif_r;
  logic [BASE_W-1:0]        base_r;
  logic signed [WIDE_W-1:0] num_left;
  logic signed [WIDE_W-1:0] num_right;

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      sum_r  <= $signed({p1[PROD_W-1], p1}) + $signed({p2[PROD_W-1], p2});
      dif_r  <= $signed({p1[PROD_W-1], p1}) - $signed({p2[PROD_W-1], p2});
      base_r <= BASE_W'(den_p[DEN_W-1:0]) * NEUTRAL_MULT;
    end
  end

  assign num_left  = $signed({2'b0, base_r}) + WIDE_W'(dif_r) * RANGE_MULT;
  assign num_right = $signed({2'b0, base_r}) + WIDE_W'(sum_r) * RANGE_MULT;

  // divider lanes
  logic [QUOT_W-1:0] q_left;
  logic [QUOT_W-1:0] q_right;

  dds_div u_div_left (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (num_left[RAW_W-1:0]),
    .divisor  (den_p[DEN_W-1:0]),
    .quot     (q_left)
  );

  dds_div u_div_right (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (num_right[RAW_W-1:0]),
    .divisor  (den_p[DEN_W-1:0]),
    .quot     (q_right)
  );

  // present duties double as the result register
  logic [DUTY_W-1:0] duty_l_r;
  logic [DUTY_W-1:0] duty_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_l_r <= DUTY_NEUTRAL;
      duty_r_r <= DUTY_NEUTRAL;
    end else if (fin_load) begin
      duty_l_r <= ramp_duty(q_left, duty_l_r, step_r);
      duty_r_r <= ramp_duty(q_right, duty_r_r, step_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty_left  = duty_l_r;
  assign out_duty_right = duty_r_r;

endmodule

`default_nettype wire

>>> rtl/dds_checker.sv
// ---------------------------------------------------------------------------
// dds_checker
// Port-level checks of the duty mixer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dds_checker
  import dds_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DUTY_W-1:0] out_duty_left,
  input wire logic [DUTY_W-1:0] out_duty_right
);

  // a taken command occupies the block, so in_ready drops after a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // duties stay within the clamp range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_left >= DUTY_MIN && out_duty_left <= DUTY_MAX &&
                  out_duty_right >= DUTY_MIN && out_duty_right <= DUTY_MAX)
    else $error("duty outside range");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_left) &&
                                $stable(out_duty_right))
    else $error("result dropped or changed while stalled");

  // reset clears any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind differential_drive_mixer_slew dds_checker u_dds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_duty_left  (out_duty_left),
  .out_duty_right (out_duty_right)
);

`default_nettype wire

>>> dv/tb_differential_drive_mixer_slew.sv
// ---------------------------------------------------------------------------
// tb_differential_drive_mixer_slew
// Drives drive and stop commands through the duty mixer under random
// handshake gaps on both channels, predicts the two ramped duties with exact
// integer arithmetic over mt*md, and checks each result transfer in order.
// Register writes over the configuration port happen only while the block
// is drained, and each write is read back.
// ---------------------------------------------------------------------------
module tb_differential_drive_mixer_slew;
  timeunit 1ns;
  timeprecision 1ps;

  import dds_pkg::*;

  localparam int  RESET_CYCLES = 4;
  localparam int  DRAIN_SLACK  = 25;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  PHASES       = 13;
  localparam int  PHASE_ITEMS  = 150;
  localparam longint DUTY_SPAN = 25;

  typedef struct packed {
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
  } duty_pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = 1'b0;
  logic [BYTE_W-1:0] in_throttle = '0;
  logic [BYTE_W-1:0] in_direction = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DUTY_W-1:0] out_duty_left;
  logic [DUTY_W-1:0] out_duty_right;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  differential_drive_mixer_slew u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_throttle   (in_throttle),
    .in_direction  (in_direction),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_duty_left (out_duty_left),
    .out_duty_right(out_duty_right),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor copy of the registers and the kept duties
  logic [BYTE_W-1:0] throttle_fs = TFS_RESET;
  logic [BYTE_W-1:0] direction_fs = DFS_RESET;
  logic [STEP_W-1:0] slew_step = STEP_RESET;
  logic [DUTY_W-1:0] left_duty = DUTY_NEUTRAL;
  logic [DUTY_W-1:0] right_duty = DUTY_NEUTRAL;

  duty_pair_t pending_duties[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;
  int         stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic longint clamp_target(longint num, longint den);
    if (num < longint'(DUTY_MIN) * den) return longint'(DUTY_MIN) * den;
    if (num > longint'(DUTY_MAX) * den) return longint'(DUTY_MAX) * den;
    return num;
  endfunction

  // move the kept duty toward num/den by at most the step, else floor
  function automatic logic [DUTY_W-1:0] slew_toward(longint num, longint den,
                                                    logic [DUTY_W-1:0] now);
    longint c;
    longint s;
    c = longint'(now);
    s = longint'(slew_step);
    if (num > (c + s) * den) return DUTY_W'(c + s);
    if (num < (c - s) * den) return DUTY_W'(c - s);
    return DUTY_W'(num / den);
  endfunction

  function automatic duty_pair_t mix_and_ramp(logic kind, logic [BYTE_W-1:0] thr,
                                              logic [BYTE_W-1:0] dir);
    longint mt, md, t, d, den, base, mix;
    duty_pair_t r;
    mt = longint'(throttle_fs) / 2;
    md = longint'(direction_fs) / 2;
    if (mt == 0) mt = 1;
    if (md == 0) md = 1;
    if (kind) begin
      t = mt;
      d = md;
    end else begin
      t = (thr > throttle_fs) ? longint'(throttle_fs) : longint'(thr);
      d = (dir > direction_fs) ? longint'(direction_fs) : longint'(dir);
    end
    den  = mt * md;
    base = longint'(DUTY_NEUTRAL) * den + DUTY_SPAN * (t - mt) * md;
    mix  = DUTY_SPAN * (d - md) * mt;
    left_duty  = slew_toward(clamp_target(base - mix, den), den, left_duty);
    right_duty = slew_toward(clamp_target(base + mix, den), den, right_duty);
    r.left  = left_duty;
    r.right = right_duty;
    return r;
  endfunction

  // result side: random stalls, compare each transfer with the oldest duty pair
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    duty_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_duties.size() == 0) begin
        report_mismatch("result with nothing pending, left", out_duty_left, 0);
      end else begin
        want = pending_duties.pop_front();
        if (out_duty_left !== want.left)
          report_mismatch("duty_left", out_duty_left, want.left);
        if (out_duty_right !== want.right)
          report_mismatch("duty_right", out_duty_right, want.right);
      end
    end
  end

  // one command transfer; valid stays up across back-to-back commands
  task automatic send_command(logic kind, logic [BYTE_W-1:0] thr,
                              logic [BYTE_W-1:0] dir);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_throttle  <= thr;
    in_direction <= dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_duties.push_back(mix_and_ramp(kind, thr, dir));
  endtask

  // drop valid and hold until every pending result has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_TFS:  throttle_fs  = value[BYTE_W-1:0];
      REG_DFS:  direction_fs = value[BYTE_W-1:0];
      REG_STEP: slew_step    = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // read back
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_TFS:  want = DATA_W'(throttle_fs);
      REG_DFS:  want = DATA_W'(direction_fs);
      default:  want = DATA_W'(slew_step);
    endcase
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [BYTE_W-1:0] tfs, logic [BYTE_W-1:0] dfs,
                            logic [STEP_W-1:0] step);
    write_reg(REG_TFS, DATA_W'(tfs));
    write_reg(REG_DFS, DATA_W'(dfs));
    write_reg(REG_STEP, DATA_W'(step));
  endtask

  // default registers: stop, saturating throttle both ways, hard turns
  task automatic test_reset_neutral();
    send_command(1'b1, 8'h00, 8'h00);
    send_command(1'b0, 8'd255, 8'd127);
    send_command(1'b0, 8'd255, 8'd127);
    send_command(1'b0, 8'd0, 8'd127);
    send_command(1'b0, 8'd0, 8'd0);
    send_command(1'b0, 8'd255, 8'd255);
    send_command(1'b0, 8'd0, 8'd255);
    send_command(1'b0, 8'd255, 8'd0);
    send_command(1'b1, 8'hff, 8'hff);
    wait_drained();
  endtask

  // inputs above the full scales are capped
  task automatic test_full_scale_cap();
    set_config(8'd100, 8'd60, 6'd49);
    send_command(1'b0, 8'd200, 8'd200);
    send_command(1'b0, 8'd255, 8'd0);
    send_command(1'b0, 8'd100, 8'd60);
    send_command(1'b0, 8'd0, 8'd61);
    send_command(1'b0, 8'd101, 8'd59);
    wait_drained();
  endtask

  // full scales of 0 and 1 give a zero midpoint, taken as 1
  task automatic test_zero_midpoint();
    set_config(8'd0, 8'd1, 6'd63);
    send_command(1'b0, 8'd0, 8'd0);
    send_command(1'b0, 8'd1, 8'd1);
    send_command(1'b0, 8'd255, 8'd255);
    send_command(1'b1, 8'd0, 8'd0);
    wait_drained();
    set_config(8'd1, 8'd0, 6'd63);
    send_command(1'b0, 8'd1, 8'd0);
    send_command(1'b0, 8'd0, 8'd255);
    wait_drained();
  endtask

  // a zero step freezes the duties unless the floored target matches
  task automatic test_zero_step();
    set_config(8'd255, 8'd255, 6'd0);
    send_command(1'b0, 8'd255, 8'd255);
    send_command(1'b0, 8'd0, 8'd0);
    wait_drained();
    write_reg(REG_STEP, DATA_W'(1));
    send_command(1'b0, 8'd255, 8'd0);
    send_command(1'b1, 8'd0, 8'd0);
    wait_drained();
  endtask

  function automatic logic [BYTE_W-1:0] pick_full_scale();
    case ($urandom_range(0, 9))
      0:       return 8'd255;
      1:       return 8'd2;
      2:       return BYTE_W'($urandom_range(0, 1));
      3:       return 8'd3;
      default: return BYTE_W'($urandom_range(2, 255));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return 6'd1;
      1:       return 6'd49;
      2:       return 6'd63;
      3:       return 6'd0;
      default: return STEP_W'($urandom_range(1, 49));
    endcase
  endfunction

  // mostly uniform bytes, some near the midpoint, some at the rails
  function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] fs);
    int mid;
    mid = int'(fs) / 2;
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3:    return BYTE_W'(mid + $urandom_range(0, 6) - 3);
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [BYTE_W-1:0] thr;
    logic [BYTE_W-1:0] dir;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_config(8'd255, 8'd255, 6'd20);
      else        set_config(pick_full_scale(), pick_full_scale(), pick_step());
      no_idle = (p == 1 || p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        thr = pick_byte(throttle_fs);
        dir = pick_byte(direction_fs);
        send_command($urandom_range(0, 9) == 0, thr, dir);
        // hold the sender until the block has fully drained
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_neutral();
    test_full_scale_cap();
    test_zero_midpoint();
    test_zero_step();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
